// File: sv/acn_pkg.sv
// ----------------------------------------------------------------------------
// acn_pkg
// shared types for the axis normalizer core and its divider
// ----------------------------------------------------------------------------
package acn_pkg;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: sv/auto_calibrating_axis_normalizer_core.sv
// ----------------------------------------------------------------------------
// auto_calibrating_axis_normalizer_core
// widens a running min/max with each sample and reports the sample's
// position in that range as an unsigned Q1.FRACTION_BITS fraction
// ----------------------------------------------------------------------------
// path: input beat, ST_PREP, ST_DIV until the divider is done, ST_OUT
// one beat at a time: no new beat is taken until the output is accepted;
//   the bit-serial divider produces one quotient bit per cycle
// empty range skips the divider: ST_PREP goes straight to ST_OUT
// reset: min to largest, max to smallest signed value, ready for a beat
// ----------------------------------------------------------------------------
module auto_calibrating_axis_normalizer_core #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] raw_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [FRACTION_BITS:0]        normalized,
	output logic signed [SAMPLE_BITS-1:0] range_low,
	output logic signed [SAMPLE_BITS-1:0] range_high
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                    state_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [FRACTION_BITS:0]        norm_q;

	logic signed [SAMPLE_BITS-1:0] new_min;
	logic signed [SAMPLE_BITS-1:0] new_max;
	logic signed [SAMPLE_BITS:0]   num_w;
	logic signed [SAMPLE_BITS:0]   den_w;
	logic                          div_start;
	logic [FRACTION_BITS:0]        div_quo;
	acn_pkg::div_status_t          div_st;
	logic                          in_beat;

	assign in_beat = in_valid && in_ready;
	assign new_min = (raw_sample < min_q) ? raw_sample : min_q;
	assign new_max = (raw_sample > max_q) ? raw_sample : max_q;

	assign num_w = {sample_q[SAMPLE_BITS-1], sample_q} - {min_q[SAMPLE_BITS-1], min_q};
	assign den_w = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};

	assign div_start = (state_q == ST_PREP) && (min_q != max_q);

	acn_divider #(
		.NUM_BITS (SAMPLE_BITS),
		.QUO_BITS (FRACTION_BITS + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_w[SAMPLE_BITS-1:0]),
		.den      (den_w[SAMPLE_BITS-1:0]),
		.quotient (div_quo),
		.status   (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						min_q   <= new_min;
						max_q   <= new_max;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (min_q == max_q) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= raw_sample;
		end
		if (state_q == ST_PREP && min_q == max_q) begin
			norm_q <= (sample_q != '0) ? {1'b1, {FRACTION_BITS{1'b0}}} : '0;
		end else if (state_q == ST_DIV && div_st.done) begin
			norm_q <= div_quo;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign normalized = norm_q;
	assign range_low  = min_q;
	assign range_high = max_q;

	// calibrated range is never inverted once a beat has gone through
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_low <= range_high)
		else $error("range_low above range_high at output");

	// fraction never exceeds 1.0
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && normalized[FRACTION_BITS] |-> normalized[FRACTION_BITS-1:0] == '0)
		else $error("normalized above 1.0");

	// divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("divider done outside divide state");

	// divider runs only for a nonempty range
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> state_q == ST_DIV && min_q != max_q)
		else $error("divider busy outside divide state");

	// an input beat always moves the sequencer on
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == ST_PREP)
		else $error("input beat did not start processing");

endmodule

// File: sv/acn_divider.sv
// ----------------------------------------------------------------------------
// acn_divider
// restoring bit-serial fraction divider, one quotient bit per cycle;
// quotient = num * 2^(QUO_BITS-1) / den for num <= den, den > 0
// ----------------------------------------------------------------------------
module acn_divider #(
	parameter int NUM_BITS = 16,
	parameter int QUO_BITS = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUM_BITS-1:0]    num,
	input  logic [NUM_BITS-1:0]    den,
	output logic [QUO_BITS-1:0]    quotient,
	output acn_pkg::div_status_t   status
);

	localparam int CNT_BITS = $clog2(QUO_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] den_q;
	logic [QUO_BITS-1:0] quo_q;

	logic [NUM_BITS:0]   trial;
	logic [NUM_BITS:0]   diff;
	logic                ge;

	// first step compares without shifting
	assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(QUO_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
